/* src/itmf_pkg.sv */
// shared constants of the bus target message framer
`default_nettype none

package itmf_pkg;

    localparam int PTR_W          = 8;
    localparam int DEFAULT_DEPTH  = 256;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_STOP    = 2'd2;
    localparam logic [1:0] OP_CONSUME = 2'd3;

    localparam logic [7:0] MARK_START = 8'h21;
    localparam logic [7:0] MARK_BODY  = 8'h3A;
    localparam logic [7:0] MARK_END   = 8'h3F;
    localparam logic [7:0] COUNT_MAX  = 8'd254;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_BODY  = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

endpackage

`default_nettype wire

/* src/i2c_target_message_framer_unit.sv */
// top level of the bus target message framer
//
// channel  dir  tdata          tuser                                    tlast
// s        in   data_byte      opcode                                   -
// m        out  read_data      message_ready, frame_kind, ignored       -
//
// after reset a sweep over every address zeroes both memories; no request taken then
// write, consume and dropped requests answer straight from idle; a read answers after the store's registered read
// stop checks the mark, then clears the store for '!', or reads the count and copies bytes to the store for ':',
// then clears the receive buffer before it answers
// one request at a time; a waiting result holds off the next request unless taken that cycle
`default_nettype none

module i2c_target_message_framer_unit #(
    parameter int BUFFER_DEPTH = itmf_pkg::DEFAULT_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  wire logic [1:0] i_s_tuser,   // [1:0] opcode
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic      [7:0] o_m_tdata,   // [7:0] read_data
    output logic      [3:0] o_m_tuser    // [0] message_ready, [2:1] frame_kind, [3] ignored
);

    import itmf_pkg::*;

    localparam int             AW     = $clog2(BUFFER_DEPTH);
    localparam logic [AW-1:0]  LAST   = AW'(BUFFER_DEPTH - 1);
    localparam logic [PTR_W:0] DEPTHX = (PTR_W + 1)'(BUFFER_DEPTH);

    localparam logic [3:0] ST_INIT   = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_READ   = 4'd2;
    localparam logic [3:0] ST_STOP   = 4'd3;
    localparam logic [3:0] ST_COUNT  = 4'd4;
    localparam logic [3:0] ST_CP_RD  = 4'd5;
    localparam logic [3:0] ST_CP_WR  = 4'd6;
    localparam logic [3:0] ST_CLR_ST = 4'd7;
    localparam logic [3:0] ST_CLR_RX = 4'd8;

    logic [3:0]       r_state, n_state;
    logic [AW-1:0]    r_cnt, n_cnt;
    logic [PTR_W-1:0] r_rx_ptr, n_rx_ptr;
    logic [PTR_W-1:0] r_reply_ptr, n_reply_ptr;
    logic             r_ready, n_ready;
    logic             r_rd_ok, n_rd_ok;
    logic [1:0]       r_kind, n_kind;
    logic [7:0]       r_count, n_count;
    logic [7:0]       r_idx, n_idx;
    logic             r_ended, n_ended;
    logic             r_m_valid, n_m_valid;
    logic [7:0]       r_m_data, n_m_data;
    logic [3:0]       r_m_user, n_m_user;

    logic          rx_we, st_we;
    logic [AW-1:0] rx_waddr, rx_raddr, st_waddr, st_raddr;
    logic [7:0]    rx_wdata, st_wdata, rx_rdata, st_rdata;

    logic          s_acc;
    logic [7:0]    cp_src;
    logic          cp_ok;
    logic [7:0]    cp_byte;

    itmf_ram #(.P_WIDTH(8), .P_DEPTH(BUFFER_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (rx_wdata),
        .i_raddr (rx_raddr),
        .o_rdata (rx_rdata)
    );

    itmf_ram #(.P_WIDTH(8), .P_DEPTH(BUFFER_DEPTH)) u_st_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    assign o_s_tready = (r_state == ST_IDLE) && (!r_m_valid || i_m_tready);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    assign cp_src  = r_idx + 8'd2;
    assign cp_ok   = {1'b0, cp_src} < DEPTHX;
    assign cp_byte = (r_ended || !cp_ok) ? 8'd0 : rx_rdata;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rx_ptr    = r_rx_ptr;
        n_reply_ptr = r_reply_ptr;
        n_ready     = r_ready;
        n_rd_ok     = r_rd_ok;
        n_kind      = r_kind;
        n_count     = r_count;
        n_idx       = r_idx;
        n_ended     = r_ended;
        n_m_valid   = r_m_valid && !i_m_tready;
        n_m_data    = r_m_data;
        n_m_user    = r_m_user;
        rx_we       = 1'b0;
        rx_waddr    = r_cnt;
        rx_wdata    = 8'd0;
        rx_raddr    = '0;
        st_we       = 1'b0;
        st_waddr    = r_cnt;
        st_wdata    = 8'd0;
        st_raddr    = r_reply_ptr[AW-1:0];

        case (r_state)
            ST_INIT: begin
                rx_we = 1'b1;
                st_we = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    if (i_s_tuser == OP_CONSUME) begin
                        n_ready   = 1'b0;
                        n_m_valid = 1'b1;
                        n_m_data  = 8'd0;
                        n_m_user  = {1'b0, KIND_OTHER, 1'b0};
                    end else if (r_ready) begin
                        n_m_valid = 1'b1;
                        n_m_data  = 8'd0;
                        n_m_user  = {1'b1, KIND_OTHER, 1'b1};
                    end else begin
                        case (i_s_tuser)
                            OP_WRITE: begin
                                rx_we     = {1'b0, r_rx_ptr} < DEPTHX;
                                rx_waddr  = r_rx_ptr[AW-1:0];
                                rx_wdata  = i_s_tdata;
                                n_rx_ptr  = r_rx_ptr + 1'b1;
                                n_m_valid = 1'b1;
                                n_m_data  = 8'd0;
                                n_m_user  = {1'b0, KIND_OTHER, 1'b0};
                            end
                            OP_READ: begin
                                n_rd_ok     = {1'b0, r_reply_ptr} < DEPTHX;
                                n_reply_ptr = r_reply_ptr + 1'b1;
                                n_state     = ST_READ;
                            end
                            OP_STOP: begin
                                n_state = ST_STOP;
                            end
                            default: begin
                                n_state = ST_IDLE;
                            end
                        endcase
                    end
                end
            end
            ST_READ: begin
                n_m_valid = 1'b1;
                n_m_data  = r_rd_ok ? st_rdata : 8'd0;
                n_m_user  = {1'b0, KIND_OTHER, r_ready};
                n_state   = ST_IDLE;
            end
            ST_STOP: begin
                rx_raddr = AW'(1);
                n_cnt    = '0;
                case (rx_rdata)
                    MARK_START: begin
                        n_kind      = KIND_START;
                        n_reply_ptr = '0;
                        n_state     = ST_CLR_ST;
                    end
                    MARK_END: begin
                        n_kind  = KIND_END;
                        n_ready = 1'b1;
                        n_state = ST_CLR_RX;
                    end
                    MARK_BODY: begin
                        n_kind      = KIND_BODY;
                        n_reply_ptr = '0;
                        n_state     = ST_COUNT;
                    end
                    default: begin
                        n_kind  = KIND_OTHER;
                        n_state = ST_CLR_RX;
                    end
                endcase
            end
            ST_COUNT: begin
                n_count = (rx_rdata > COUNT_MAX) ? COUNT_MAX : rx_rdata;
                n_idx   = 8'd0;
                n_ended = 1'b0;
                n_state = (rx_rdata == 8'd0) ? ST_CLR_RX : ST_CP_RD;
            end
            ST_CP_RD: begin
                rx_raddr = cp_src[AW-1:0];
                n_state  = ST_CP_WR;
            end
            ST_CP_WR: begin
                st_we    = {1'b0, r_idx} < DEPTHX;
                st_waddr = r_idx[AW-1:0];
                st_wdata = cp_byte;
                if (cp_byte == 8'd0) begin
                    n_ended = 1'b1;
                end
                n_idx = r_idx + 1'b1;
                if (n_idx == r_count) begin
                    n_state = ST_CLR_RX;
                end else begin
                    n_state = ST_CP_RD;
                end
            end
            ST_CLR_ST: begin
                st_we = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_cnt   = '0;
                    n_state = ST_CLR_RX;
                end
            end
            ST_CLR_RX: begin
                rx_we = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_cnt     = '0;
                    n_rx_ptr  = '0;
                    n_m_valid = 1'b1;
                    n_m_data  = 8'd0;
                    n_m_user  = {1'b0, r_kind, r_ready};
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_cnt       <= '0;
            r_rx_ptr    <= '0;
            r_reply_ptr <= '0;
            r_ready     <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rx_ptr    <= n_rx_ptr;
            r_reply_ptr <= n_reply_ptr;
            r_ready     <= n_ready;
            r_m_valid   <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok  <= n_rd_ok;
        r_kind   <= n_kind;
        r_count  <= n_count;
        r_idx    <= n_idx;
        r_ended  <= n_ended;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
    end

endmodule

`default_nettype wire

/* src/itmf_ram.sv */
// generic single-port-write ram with registered read
`default_nettype none

module itmf_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 256
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  wire logic [P_WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic      [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
